// ===== hw/rtl/markup_entity_text_segmenter_defines.svh =====
// Assertion macros shared by the segmenter RTL.
`ifndef MARKUP_ENTITY_TEXT_SEGMENTER_DEFINES_SVH
`define MARKUP_ENTITY_TEXT_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define METS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segmenter assertion failed");

// Next-cycle implication, disabled during reset.
`define METS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segmenter assertion failed");

`endif

// ===== hw/rtl/mets_pkg.sv =====
`default_nettype none
package mets_pkg;

    localparam int MAX_BYTES  = 64;
    localparam int IDX_W      = $clog2(MAX_BYTES);
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);
    localparam int NUM_BANKS  = 2;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int RAM_DEPTH  = NUM_BANKS * MAX_BYTES;
    localparam int RAM_AW     = BANK_W + IDX_W;
    localparam int OUTST_W    = $clog2(NUM_BANKS + 1);
    localparam int START_W    = 6;
    localparam int LENGTH_W   = 7;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_MARKUP = 2'd1,
        KIND_ENTITY = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_MARKUP,
        S_ENTITY,
        S_TEXT
    } t_scan_state;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [CNT_W-1:0]  len;
        logic              ovf;
    } t_job;

    typedef struct packed {
        logic                trunc;
        logic                last_seg;
        logic [LENGTH_W-1:0] length;
        logic [START_W-1:0]  start;
        t_kind               kind;
    } t_seg;

endpackage
`default_nettype wire

// ===== hw/rtl/mets_ram.sv =====
`default_nettype none
module mets_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mets_fifo.sv =====
`default_nettype none
module mets_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mets_pkg::t_job i_data,
    input  wire logic          i_pop,
    output mets_pkg::t_job     o_data,
    output logic               o_empty
);
    import mets_pkg::*;

    t_job                r_mem [NUM_BANKS];
    logic [BANK_W-1:0]   r_wptr, n_wptr;
    logic [BANK_W-1:0]   r_rptr, n_rptr;
    logic [OUTST_W-1:0]  r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + BANK_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + BANK_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + OUTST_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - OUTST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/mets_front.sv =====
`default_nettype none
`include "markup_entity_text_segmenter_defines.svh"
module mets_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,
    input  wire logic                          i_s_tlast,
    output logic                               o_we,
    output logic [mets_pkg::RAM_AW-1:0]        o_waddr,
    output logic [7:0]                         o_wdata,
    output logic                               o_push,
    output mets_pkg::t_job                     o_job,
    input  wire logic                          i_done
);
    import mets_pkg::*;

    logic [BANK_W-1:0]  r_bank, n_bank;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic               r_ovf, n_ovf;
    logic [OUTST_W-1:0] r_outstanding, n_outstanding;
    logic               w_accept;
    logic               w_room;

    assign o_s_tready = (r_outstanding < OUTST_W'(NUM_BANKS));
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_room     = (r_fill < CNT_W'(MAX_BYTES));

    assign o_we    = w_accept && w_room;
    assign o_waddr = {r_bank, r_fill[IDX_W-1:0]};
    assign o_wdata = i_s_tdata;
    assign o_push  = w_accept && i_s_tlast;

    always_comb begin
        o_job.bank = r_bank;
        o_job.len  = w_room ? r_fill + CNT_W'(1) : r_fill;
        o_job.ovf  = r_ovf || !w_room;
    end

    always_comb begin
        n_bank        = r_bank;
        n_fill        = r_fill;
        n_ovf         = r_ovf;
        n_outstanding = r_outstanding;
        if (w_accept) begin
            if (i_s_tlast) begin
                n_fill = '0;
                n_ovf  = 1'b0;
                n_bank = r_bank + BANK_W'(1);
            end else if (w_room) begin
                n_fill = r_fill + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (o_push && !i_done) begin
            n_outstanding = r_outstanding + OUTST_W'(1);
        end else if (!o_push && i_done) begin
            n_outstanding = r_outstanding - OUTST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank        <= '0;
            r_fill        <= '0;
            r_ovf         <= 1'b0;
            r_outstanding <= '0;
        end else begin
            r_bank        <= n_bank;
            r_fill        <= n_fill;
            r_ovf         <= n_ovf;
            r_outstanding <= n_outstanding;
        end
    end

    `METS_ASSERT_IMP(a_outstanding_max, i_clk, i_rst_n, 1'b1, r_outstanding <= OUTST_W'(NUM_BANKS))
    `METS_ASSERT_NXT(a_last_clears_fill, i_clk, i_rst_n, o_push, r_fill == '0 && !r_ovf)
    `METS_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(MAX_BYTES))

endmodule
`default_nettype wire

// ===== hw/rtl/mets_scan.sv =====
`default_nettype none
`include "markup_entity_text_segmenter_defines.svh"
module mets_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire mets_pkg::t_job                i_q_job,
    output logic                               o_q_pop,
    output logic [mets_pkg::RAM_AW-1:0]        o_raddr,
    input  wire logic [7:0]                    i_rd_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output mets_pkg::t_seg                     o_seg,
    output logic                               o_done
);
    import mets_pkg::*;

    t_scan_state       r_state, n_state;
    logic [BANK_W-1:0] r_bank, n_bank;
    logic [CNT_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_cur, n_cur;
    logic              r_quoted, n_quoted;
    logic [7:0]        r_quote, n_quote;
    logic              r_ovld, n_ovld;
    t_seg              r_seg, n_seg;

    logic              w_in_range;
    logic              w_breaker;
    logic              w_seg_ready;
    logic              w_ent_fail;
    logic [CNT_W-1:0]  w_end;
    t_kind             w_kind;
    logic              w_fire;
    logic              w_last;

    assign w_in_range = (r_cur < r_len);
    assign w_breaker  = (i_rd_data == CH_LT) || (i_rd_data == CH_AMP) ||
                        (i_rd_data == CH_SP) || (i_rd_data == CH_TAB) ||
                        (i_rd_data == CH_CR) || (i_rd_data == CH_LF);

    always_comb begin
        w_seg_ready = 1'b0;
        w_ent_fail  = 1'b0;
        w_end       = r_cur;
        w_kind      = KIND_TEXT;
        unique case (r_state)
            S_MARKUP: begin
                w_kind = KIND_MARKUP;
                if (!w_in_range) begin
                    w_seg_ready = 1'b1;
                    w_end       = r_pos + CNT_W'(1);
                end else if (!r_quoted && i_rd_data == CH_GT) begin
                    w_seg_ready = 1'b1;
                    w_end       = r_cur + CNT_W'(1);
                end
            end
            S_ENTITY: begin
                w_kind = KIND_ENTITY;
                if (w_in_range && i_rd_data == CH_SEMI) begin
                    w_seg_ready = 1'b1;
                    w_end       = r_cur + CNT_W'(1);
                end else if (!w_in_range || w_breaker) begin
                    w_ent_fail = 1'b1;
                end
            end
            S_TEXT: begin
                if (!w_in_range || i_rd_data == CH_LT || i_rd_data == CH_AMP) begin
                    w_seg_ready = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_fire = w_seg_ready && (!r_ovld || i_ready);
    assign w_last = (w_end >= r_len);
    assign o_done = w_fire && w_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_rd_data == CH_LT) begin
                    n_state = S_MARKUP;
                end else if (i_rd_data == CH_AMP) begin
                    n_state = S_ENTITY;
                end else begin
                    n_state = S_TEXT;
                end
            end
            S_MARKUP, S_TEXT: begin
                if (w_fire) begin
                    n_state = w_last ? S_IDLE : S_HEAD;
                end
            end
            S_ENTITY: begin
                if (w_fire) begin
                    n_state = w_last ? S_IDLE : S_HEAD;
                end else if (w_ent_fail) begin
                    n_state = S_TEXT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_q_pop  = 1'b0;
        n_bank   = r_bank;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_pos    = r_pos;
        n_cur    = r_cur;
        n_quoted = r_quoted;
        n_quote  = r_quote;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_bank  = i_q_job.bank;
                    n_len   = i_q_job.len;
                    n_ovf   = i_q_job.ovf;
                    n_pos   = '0;
                    n_cur   = '0;
                end
            end
            S_HEAD: begin
                n_cur    = r_pos + CNT_W'(1);
                n_quoted = 1'b0;
            end
            S_MARKUP: begin
                if (w_fire) begin
                    n_pos = w_end;
                    n_cur = w_end;
                end else if (!w_seg_ready) begin
                    n_cur = r_cur + CNT_W'(1);
                    if (r_quoted) begin
                        if (i_rd_data == r_quote) begin
                            n_quoted = 1'b0;
                        end
                    end else if (i_rd_data == CH_SQ || i_rd_data == CH_DQ) begin
                        n_quoted = 1'b1;
                        n_quote  = i_rd_data;
                    end
                end
            end
            S_ENTITY: begin
                if (w_fire) begin
                    n_pos = w_end;
                    n_cur = w_end;
                end else if (w_ent_fail) begin
                    n_cur = r_pos + CNT_W'(1);
                end else if (!w_seg_ready) begin
                    n_cur = r_cur + CNT_W'(1);
                end
            end
            S_TEXT: begin
                if (w_fire) begin
                    n_pos = w_end;
                    n_cur = w_end;
                end else if (!w_seg_ready) begin
                    n_cur = r_cur + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        n_ovld = r_ovld && !i_ready;
        n_seg  = r_seg;
        if (w_fire) begin
            n_ovld         = 1'b1;
            n_seg.kind     = w_kind;
            n_seg.start    = START_W'(r_pos);
            n_seg.length   = LENGTH_W'(w_end - r_pos);
            n_seg.last_seg = w_last;
            n_seg.trunc    = r_ovf;
        end
    end

    assign o_raddr = {n_bank, n_cur[IDX_W-1:0]};
    assign o_valid = r_ovld;
    assign o_seg   = r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank   <= n_bank;
        r_len    <= n_len;
        r_ovf    <= n_ovf;
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_quoted <= n_quoted;
        r_quote  <= n_quote;
        r_seg    <= n_seg;
    end

    `METS_ASSERT_IMP(a_cur_bounded, i_clk, i_rst_n, r_state != S_IDLE, r_cur <= r_len)
    `METS_ASSERT_IMP(a_seg_nonzero, i_clk, i_rst_n, r_ovld, r_seg.length != '0)
    `METS_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE)

endmodule
`default_nettype wire

// ===== hw/rtl/markup_entity_text_segmenter.sv =====
// Splits one annotation string into text, markup and entity segments. Bytes
// stream in one word per cycle into a two-bank buffer of 64 bytes per bank;
// bytes past 64 are dropped and the segments of that string carry the
// truncated flag. The word marked tlast closes the string and queues it for
// the scanner, which reads one buffer byte per cycle while its output is not
// held. It takes each string from the queue while idle and reads one byte
// past the end of each text segment. A '<' without a closing '>' or an '&'
// that does not end in ';' makes the scanner walk back to the byte after it,
// so the scanner may read a byte of the string again. While one string is
// scanned the next one loads into the other bank; the input stalls only when
// both banks hold strings not yet scanned.
`default_nettype none
module markup_entity_text_segmenter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] string byte
    input  wire logic        i_s_tlast,   // is_last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [5:0] seg_start, [12:6] seg_length, zero fill
    output logic [2:0]       o_m_tuser,   // [1:0] seg_kind, [2] truncated
    output logic             o_m_tlast    // final_segment
);
    import mets_pkg::*;

    logic              w_we;
    logic [RAM_AW-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic [RAM_AW-1:0] w_raddr;
    logic [7:0]        w_rdata;
    logic              w_push;
    t_job              w_job_in;
    t_job              w_job_out;
    logic              w_pop;
    logic              w_empty;
    logic              w_done;
    t_seg              w_seg;

    mets_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .i_done     (w_done)
    );

    mets_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mets_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    mets_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_job   (w_job_out),
        .o_q_pop   (w_pop),
        .o_raddr   (w_raddr),
        .i_rd_data (w_rdata),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_seg     (w_seg),
        .o_done    (w_done)
    );

    assign o_m_tdata = {3'b000, w_seg.length, w_seg.start};
    assign o_m_tuser = {w_seg.trunc, w_seg.kind};
    assign o_m_tlast = w_seg.last_seg;

endmodule
`default_nettype wire
